>>> src/ttps_pkg.sv
package ttps_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 65536;
    localparam int unsigned HASH_W = 64;

    localparam logic [1:0] FLAG_EXACT = 2'd0;
    localparam logic [1:0] FLAG_LOWER = 2'd1;
    localparam logic [1:0] FLAG_UPPER = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [63:0]        position_hash;
        logic [5:0]         search_depth;
        logic signed [15:0] alpha_in;
        logic signed [15:0] beta_in;
        logic signed [15:0] result_score;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] score_out;
        logic signed [15:0] alpha_out;
        logic signed [15:0] beta_out;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         flag;
        logic [5:0]         depth;
        logic signed [15:0] score;
        logic [63:0]        key;
    } entry_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic index_step;
        logic access;
        logic resolve;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic index_last;
        logic fast_index;
    } ctrl_sts_t;

endpackage

>>> src/transposition_table_probe_store.sv
// An accepted start passes the lookup and resolve states to reach the done strobe; if
// TABLE_ENTRIES is not a power of two, an index state first reduces the hash modulo it, a byte at a time.
// A new transaction is accepted only while busy is low; busy falls as done is raised.
// Reset: busy stays high for a clearing pass that writes every entry with valid low.
// done lasts one cycle and cannot be stalled by the receiver.
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ttps_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    ttps_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .request(request),
        .sts    (sts),
        .result (result)
    );

endmodule

>>> src/ttps_index.sv
module ttps_index
    import ttps_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               step,
    input  logic [HASH_W-1:0]  hash,
    output logic [IDX_W-1:0]   idx,
    output logic               last,
    output logic               fast
);

    localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
    localparam int unsigned T_W = IDX_W + 8;
    localparam longint unsigned RECIP = (64'd1 << T_W) / TABLE_ENTRIES;
    localparam logic [8:0] RECIP_C = 9'(RECIP);
    localparam logic [T_W-1:0] N_C = T_W'(TABLE_ENTRIES);

    logic [HASH_W-1:0] shift_reg, shift_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [T_W-1:0]    part_reg, part_next;
    logic [8:0]        quot_reg, quot_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [T_W-1:0]    part;
    logic [T_W-1:0]    diff;

    // remainder one hash byte per even/odd step pair, msb first:
    // even step estimates the quotient by reciprocal, odd step subtracts and corrects
    always_comb
    begin
        part = {rem_reg, shift_reg[HASH_W-1 -: 8]};
        diff = part_reg - T_W'(quot_reg) * N_C;
        shift_next = shift_reg;
        rem_next = rem_reg;
        part_next = part_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            shift_next = hash;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            if (!cnt_reg[0])
            begin
                shift_next = {shift_reg[HASH_W-9:0], 8'd0};
                part_next = part;
                quot_next = 9'(((T_W+9)'(part) * (T_W+9)'(RECIP_C)) >> T_W);
            end
            else
            begin
                if (diff >= N_C)
                    rem_next = IDX_W'(diff - N_C);
                else
                    rem_next = IDX_W'(diff);
            end
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        part_reg <= part_next;
        quot_reg <= quot_next;
    end

    assign idx  = IS_POW2 ? shift_reg[IDX_W-1:0] : rem_reg;
    assign last = (cnt_reg == 4'd15);
    assign fast = IS_POW2;

endmodule

>>> src/ttps_datapath.sv
module ttps_datapath
    import ttps_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    input  req_t      request,
    output ctrl_sts_t sts,
    output rsp_t      result
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];

    req_t             req_reg;
    entry_t           rd_reg;
    rsp_t             rsp_reg, rsp_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] addr;
    logic             wr_en;
    entry_t           wr_data;
    logic [1:0]       new_flag;
    logic             match;
    logic signed [15:0] a_n, b_n;

    ttps_index #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_index (
        .clk  (clk),
        .rst_n(rst_n),
        .load (cmd.accept),
        .step (cmd.index_step),
        .hash (request.position_hash),
        .idx  (idx),
        .last (sts.index_last),
        .fast (sts.fast_index)
    );

    assign sts.clear_last = (clr_reg == LAST_IDX);

    always_comb
    begin
        if (req_reg.result_score <= req_reg.alpha_in)
            new_flag = FLAG_UPPER;
        else if (req_reg.result_score >= req_reg.beta_in)
            new_flag = FLAG_LOWER;
        else
            new_flag = FLAG_EXACT;

        addr = cmd.clear_wr ? clr_reg : idx;
        wr_en = cmd.clear_wr || (cmd.access && req_reg.mode);
        wr_data.valid = !cmd.clear_wr;
        wr_data.flag  = new_flag;
        wr_data.depth = req_reg.search_depth;
        wr_data.score = req_reg.result_score;
        wr_data.key   = req_reg.position_hash;

        clr_next = cmd.clear_wr ? clr_reg + 1'b1 : clr_reg;
    end

    // probe resolution; a store reports a hit with its own score
    always_comb
    begin
        match = rd_reg.valid && (rd_reg.key == req_reg.position_hash)
                && (rd_reg.depth >= req_reg.search_depth);
        a_n = req_reg.alpha_in;
        b_n = req_reg.beta_in;
        rsp_next.hit = 1'b0;
        rsp_next.score_out = '0;
        if (req_reg.mode)
        begin
            rsp_next.hit = 1'b1;
            rsp_next.score_out = req_reg.result_score;
        end
        else if (match)
        begin
            if (rd_reg.flag == FLAG_EXACT)
            begin
                rsp_next.hit = 1'b1;
                rsp_next.score_out = rd_reg.score;
            end
            else
            begin
                if (rd_reg.flag == FLAG_LOWER && rd_reg.score > a_n)
                    a_n = rd_reg.score;
                else if (rd_reg.flag == FLAG_UPPER && rd_reg.score < b_n)
                    b_n = rd_reg.score;
                if (a_n >= b_n)
                begin
                    rsp_next.hit = 1'b1;
                    rsp_next.score_out = rd_reg.score;
                end
            end
        end
        rsp_next.alpha_out = a_n;
        rsp_next.beta_out = b_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            req_reg <= request;
        if (cmd.resolve)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wr_data;
        if (cmd.access)
            rd_reg <= mem[addr];
    end

    assign result = rsp_reg;

endmodule

>>> src/ttps_ctrl.sv
module ttps_ctrl
    import ttps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_LOOKUP,
        S_RESOLVE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd.clear_wr   = (state_reg == S_CLEAR);
        cmd.accept     = start && !busy_reg;
        cmd.index_step = (state_reg == S_INDEX);
        cmd.access     = (state_reg == S_LOOKUP);
        cmd.resolve    = (state_reg == S_RESOLVE);
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                    busy_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.fast_index ? S_LOOKUP : S_INDEX;
                    busy_next = 1'b1;
                end
            end
            S_INDEX:
            begin
                if (sts.index_last)
                    state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                state_next = S_IDLE;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> sim/tb_transposition_table_probe_store.sv
`timescale 1ns / 100ps

module tb_transposition_table_probe_store;
    import ttps_pkg::*;

    localparam logic MODE_PROBE = 1'b0;
    localparam logic MODE_STORE = 1'b1;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CLOSING_ITEMS = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    entry_t table_mirror [TABLE_ENTRIES_DEF];
    rsp_t pending_results [$];
    logic [63:0] stored_keys [$];
    rsp_t want;
    int error_count = 0;
    int stall_cycles = 0;
    bit idling_on = 1'b1;

    transposition_table_probe_store uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic int unsigned slot_of(input logic [63:0] key);
        return int'(key % TABLE_ENTRIES_DEF);
    endfunction

    function automatic rsp_t predict_table_access(input req_t r);
        int unsigned slot;
        entry_t e;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] s;
        logic signed [15:0] es;
        rsp_t o;
        slot = slot_of(r.position_hash);
        a = r.alpha_in;
        b = r.beta_in;
        s = r.result_score;
        o = '0;
        if (r.mode == MODE_STORE)
        begin
            e.valid = 1'b1;
            if (s <= a)
                e.flag = FLAG_UPPER;
            else if (s >= b)
                e.flag = FLAG_LOWER;
            else
                e.flag = FLAG_EXACT;
            e.depth = r.search_depth;
            e.score = s;
            e.key = r.position_hash;
            table_mirror[slot] = e;
            o.hit = 1'b1;
            o.score_out = s;
        end
        else
        begin
            e = table_mirror[slot];
            es = e.score;
            if (e.valid && e.key == r.position_hash && e.depth >= r.search_depth)
            begin
                if (e.flag == FLAG_EXACT)
                begin
                    o.hit = 1'b1;
                    o.score_out = es;
                end
                else
                begin
                    if (e.flag == FLAG_LOWER && es > a)
                        a = es;
                    else if (e.flag == FLAG_UPPER && es < b)
                        b = es;
                    if (a >= b)
                    begin
                        o.hit = 1'b1;
                        o.score_out = es;
                    end
                end
            end
        end
        o.alpha_out = a;
        o.beta_out = b;
        return o;
    endfunction

    task automatic send_item(input req_t r);
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_table_access(r));
        if (idling_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_req(input logic mode, input logic [63:0] hash, input int depth,
                            input int alpha, input int beta, input int score);
        req_t r;
        r.mode = mode;
        r.position_hash = hash;
        r.search_depth = 6'(depth);
        r.alpha_in = clamp16(alpha);
        r.beta_in = clamp16(beta);
        r.result_score = clamp16(score);
        send_item(r);
    endtask

    task automatic test_store_classification();
        send_req(MODE_STORE, 64'h0, 10, -100, 100, 5);
        send_req(MODE_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 63, -100, 100, -100);
        send_req(MODE_STORE, 64'h1234_5678_9ABC_0001, 20, -100, 100, 100);
        send_req(MODE_STORE, 64'h1234_5678_9ABC_0002, 20, 50, -50, 50);
        send_req(MODE_STORE, 64'h1234_5678_9ABC_0003, 0, 50, 50, 60);
        send_req(MODE_STORE, 64'h8000_0000_0000_0004, 0, -32768, 32767, 32767);
        send_req(MODE_STORE, 64'h7FFF_FFFF_FFFF_0005, 63, -32768, 32767, -32768);
    endtask

    task automatic test_probe_outcomes();
        send_req(MODE_PROBE, 64'h0, 10, 0, 1, 0);
        send_req(MODE_PROBE, 64'h0, 11, 0, 1, -1);
        send_req(MODE_PROBE, 64'hAAAA_0000_0000_0000, 0, 0, 1, 0);
        send_req(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 63, -200, 0, 0);
        send_req(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 63, -100, 0, 0);
        send_req(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, -200, -150, 0);
        send_req(MODE_PROBE, 64'h1234_5678_9ABC_0001, 0, 0, 200, 0);
        send_req(MODE_PROBE, 64'h1234_5678_9ABC_0001, 20, 0, 100, 0);
        send_req(MODE_PROBE, 64'h1234_5678_9ABC_0001, 5, 150, 200, 0);
        send_req(MODE_PROBE, 64'h1234_5678_9ABC_0001, 5, 300, 200, 0);
    endtask

    task automatic test_same_entry_forwarding();
        bit saved;
        saved = idling_on;
        idling_on = 1'b0;
        send_req(MODE_STORE, 64'h0F0F_0000_0000_1111, 7, -10, 10, 7);
        send_req(MODE_PROBE, 64'h0F0F_0000_0000_1111, 7, -10, 10, 0);
        send_req(MODE_STORE, 64'hF0F0_0000_0000_1111, 3, -10, 10, -3);
        send_req(MODE_PROBE, 64'h0F0F_0000_0000_1111, 0, -10, 10, 0);
        send_req(MODE_PROBE, 64'hF0F0_0000_0000_1111, 3, -10, 10, 0);
        idling_on = saved;
    endtask

    task automatic send_random_item();
        req_t r;
        logic [63:0] key;
        entry_t e;
        int base;
        r.result_score = 16'($urandom);
        r.alpha_in = 16'($urandom);
        r.beta_in = 16'($urandom);
        r.search_depth = 6'($urandom_range(0, 63));
        if (stored_keys.size() == 0 || $urandom_range(0, 99) < 35)
        begin
            r.mode = MODE_STORE;
            if (stored_keys.size() != 0 && $urandom_range(0, 3) == 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
            begin
                key = {$urandom, $urandom};
                if ($urandom_range(0, 1))
                    key[15:0] = 16'($urandom_range(0, 31));
                stored_keys.push_back(key);
            end
            r.position_hash = key;
            case ($urandom_range(0, 3))
                1, 2:
                begin
                    base = int'($urandom_range(0, 65535)) - 32768;
                    r.alpha_in = clamp16(base - int'($urandom_range(0, 200)));
                    r.beta_in = clamp16(base + int'($urandom_range(0, 200)));
                    r.result_score = clamp16(base + int'($urandom_range(0, 500)) - 250);
                end
                3:
                    r.result_score = $urandom_range(0, 1) ? r.alpha_in : r.beta_in;
                default:
                    ;
            endcase
        end
        else
        begin
            r.mode = MODE_PROBE;
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            if ($urandom_range(0, 9) == 0)
                key = key ^ (64'd1 << $urandom_range(16, 63));
            r.position_hash = key;
            e = table_mirror[slot_of(key)];
            if ($urandom_range(0, 3) != 0)
                r.search_depth = 6'($urandom_range(0, e.depth));
            if ($urandom_range(0, 9) < 7)
            begin
                base = e.score;
                r.alpha_in = clamp16(base + int'($urandom_range(0, 250)) - 150);
                r.beta_in = clamp16(base + int'($urandom_range(0, 250)) - 100);
            end
        end
        send_item(r);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 149) == 0)
                idling_on = !idling_on;
            send_random_item();
        end
    endtask

    task automatic test_closing_stream();
        idling_on = 1'b0;
        for (int i = 0; i < CLOSING_ITEMS; i++)
            send_random_item();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got %p", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, result.hit);
                    error_count++;
                end
                if (result.score_out !== want.score_out)
                begin
                    $display("%0t: score_out expected %0d got %0d", $time,
                             want.score_out, result.score_out);
                    error_count++;
                end
                if (result.alpha_out !== want.alpha_out)
                begin
                    $display("%0t: alpha_out expected %0d got %0d", $time,
                             want.alpha_out, result.alpha_out);
                    error_count++;
                end
                if (result.beta_out !== want.beta_out)
                begin
                    $display("%0t: beta_out expected %0d got %0d", $time,
                             want.beta_out, result.beta_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (start && !busy)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transaction accepted", $time);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int drain_cycles;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            table_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_store_classification();
        test_probe_outcomes();
        test_same_entry_forwarding();
        test_random_traffic();
        test_closing_stream();
        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d transactions outstanding, expected none", $time,
                     pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
